[rtl/cnpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnpr_pkg
// Widths, register indexes, status codes and saturating fixed-point helpers
// for the complex Newton polynomial root core.
// ----------------------------------------------------------------------------
package cnpr_pkg;

	localparam int WORD_BITS = 40;
	localparam int FRAC_BITS = 24;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int HALF_BITS = WORD_BITS / 2;
	localparam int TOL_BITS = 24;
	localparam int LIM_BITS = 6;
	localparam int IDX_BITS = 3;
	localparam int NUM_COEF = 5;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	localparam logic [IDX_BITS-1:0] REG_COEF_X4 = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_COEF_X0 = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_TOL = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_LIMIT = 3'd6;

	localparam logic [1:0] ST_ITER = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;
	localparam logic [1:0] ST_ZERO_D = 2'd3;

	localparam word_t VMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	localparam word_t RST_X4 = 40'sd11744051;
	localparam word_t RST_X3 = -40'sd130358968;
	localparam word_t RST_X2 = 40'sd369786618;
	localparam word_t RST_X1 = -40'sd296661444;
	localparam word_t RST_X0 = -40'sd4638237188;
	localparam logic [TOL_BITS-1:0] RST_TOL = 24'd2;
	localparam logic [LIM_BITS-1:0] RST_LIMIT = 6'd63;

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? VMIN : VMAX;
		return s[WORD_BITS-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? VMIN : VMAX;
		return s[WORD_BITS-1:0];
	endfunction

	// round half away from zero at FRAC_BITS, then saturate
	function automatic word_t round_sat(input prod_t p);
		logic [PROD_BITS:0] t;
		logic [PROD_BITS-FRAC_BITS:0] y;
		t = {p[PROD_BITS-1], p} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1))
			- (PROD_BITS+1)'(p[PROD_BITS-1]);
		y = t[PROD_BITS:FRAC_BITS];
		if (y[PROD_BITS-FRAC_BITS:WORD_BITS-1] != '0 &&
			y[PROD_BITS-FRAC_BITS:WORD_BITS-1] != '1)
			return y[PROD_BITS-FRAC_BITS] ? VMIN : VMAX;
		return y[WORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/complex_newton_poly_root_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_newton_poly_root_core
// Newton-Raphson root refiner for a monic degree-5 real polynomial, complex
// Horner evaluation and long division on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, start_re/start_im) takes one start
//   point; in_ready is high only while the core is idle.
//   Output channel (out_valid/out_ready) gives one result per iterate, the
//   start point first; last marks the final one, status tells why it ended.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while idle. Index 0..4 are coef_x4..coef_x0, 5 tolerance,
//   6 iteration limit.
//   Datapath: every real product is formed from two partial products on the
//   shared 40x21 multiplier, and Horner products then take a round step. One
//   iterate runs 7 complex products in Horner, 9 exact products, two 41-step
//   restoring divisions and the setup and decision states. Up to 63 steps.
//   A result sits in an output register; the core keeps working and only
//   waits when the next result is ready while the previous one is unsent.
//   Reset restores the documented register values and idles the core.
// ----------------------------------------------------------------------------
module complex_newton_poly_root_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire cnpr_pkg::word_t         start_re,
	input  wire cnpr_pkg::word_t         start_im,
	output logic                         out_valid,
	input  wire                          out_ready,
	output cnpr_pkg::word_t              z_re,
	output cnpr_pkg::word_t              z_im,
	output cnpr_pkg::word_t              f_re,
	output cnpr_pkg::word_t              f_im,
	output logic [1:0]                   status,
	output logic                         last,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [cnpr_pkg::IDX_BITS-1:0] cfg_index,
	input  wire cnpr_pkg::word_t         cfg_data
);
	import cnpr_pkg::*;

	localparam int SW = 4;
	localparam logic [SW-1:0] S_IDLE = 4'd0;
	localparam logic [SW-1:0] S_INIT = 4'd1;
	localparam logic [SW-1:0] S_INITD = 4'd2;
	localparam logic [SW-1:0] S_MUL0 = 4'd3;
	localparam logic [SW-1:0] S_MUL1 = 4'd4;
	localparam logic [SW-1:0] S_RND = 4'd5;
	localparam logic [SW-1:0] S_CMB = 4'd6;
	localparam logic [SW-1:0] S_ADD = 4'd7;
	localparam logic [SW-1:0] S_EXP = 4'd8;
	localparam logic [SW-1:0] S_DEC = 4'd9;
	localparam logic [SW-1:0] S_DVS = 4'd10;
	localparam logic [SW-1:0] S_DVI = 4'd11;
	localparam logic [SW-1:0] S_DVF = 4'd12;

	localparam int OVS = WORD_BITS - FRAC_BITS;
	localparam int QW = WORD_BITS + 1;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] DIV_STEPS = CW'(QW - 1);
	localparam logic [QW-1:0] CAP_POS = (QW'(1) << (WORD_BITS - 1)) - QW'(1);
	localparam logic [QW-1:0] CAP_NEG = QW'(1) << (WORD_BITS - 1);

	logic [SW-1:0] state_q;
	word_t coef_q [NUM_COEF];
	logic [TOL_BITS-1:0] tol_q;
	logic [LIM_BITS-1:0] limit_q;

	word_t zre_q, zim_q, pre_q, pim_q, dre_q, dim_q;
	word_t r_q [4];
	word_t cr_q, ci_q;
	logic exact_q, sel_d_q, nsel_q;
	logic [3:0] j_q;
	logic [2:0] k_q;
	logic [LIM_BITS-1:0] n_q;

	prod_t prod_q;
	logic [PROD_BITS:0] fsq_q, dsq_q;
	logic [2*TOL_BITS-1:0] tol2_q;
	logic signed [PROD_BITS:0] nre_q, nim_q;

	logic [PROD_BITS:0] rem_q;
	logic [QW-1:0] nlo_q, q_q;
	logic [CW-1:0] cnt_q;
	logic dneg_q, ovf_q;

	word_t mul_a, mul_b, ar, ai;
	logic signed [WORD_BITS-HALF_BITS:0] mul_bp;
	logic signed [WORD_BITS+WORD_BITS-HALF_BITS:0] pp;
	logic [1:0] st_c;
	logic out_load;
	logic signed [PROD_BITS:0] nval;
	logic [PROD_BITS:0] nmag;
	logic [PROD_BITS+1:0] r2;
	logic [QW-1:0] qr, qv;
	word_t qs;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// shared multiplier operand select
	always_comb begin
		ar = sel_d_q ? dre_q : pre_q;
		ai = sel_d_q ? dim_q : pim_q;
		mul_a = '0;
		mul_b = '0;
		if (!exact_q) begin
			case (j_q[1:0])
				2'd0: begin mul_a = ar; mul_b = zre_q; end
				2'd1: begin mul_a = ai; mul_b = zim_q; end
				2'd2: begin mul_a = ar; mul_b = zim_q; end
				default: begin mul_a = ai; mul_b = zre_q; end
			endcase
		end else begin
			case (j_q)
				4'd0: begin mul_a = pre_q; mul_b = pre_q; end
				4'd1: begin mul_a = pim_q; mul_b = pim_q; end
				4'd2: begin mul_a = dre_q; mul_b = dre_q; end
				4'd3: begin mul_a = dim_q; mul_b = dim_q; end
				4'd4: begin
					mul_a = WORD_BITS'(tol_q);
					mul_b = WORD_BITS'(tol_q);
				end
				4'd5: begin mul_a = pre_q; mul_b = dre_q; end
				4'd6: begin mul_a = pim_q; mul_b = dim_q; end
				4'd7: begin mul_a = pim_q; mul_b = dre_q; end
				default: begin mul_a = pre_q; mul_b = dim_q; end
			endcase
		end
		if (state_q == S_MUL0)
			mul_bp = $signed({1'b0, mul_b[HALF_BITS-1:0]});
		else
			mul_bp = $signed({mul_b[WORD_BITS-1], mul_b[WORD_BITS-1:HALF_BITS]});
		pp = mul_a * mul_bp;
	end

	// divider datapath
	always_comb begin
		nval = nsel_q ? nim_q : nre_q;
		nmag = nval[PROD_BITS] ? (PROD_BITS+1)'(-nval) : nval;
		r2 = {rem_q, nlo_q[QW-1]};
		qr = {1'b0, q_q[QW-1:1]} + QW'(q_q[0]);
		if (ovf_q || qr > (dneg_q ? CAP_NEG : CAP_POS))
			qv = dneg_q ? CAP_NEG : CAP_POS;
		else
			qv = qr;
		qs = dneg_q ? -qv[WORD_BITS-1:0] : qv[WORD_BITS-1:0];
	end

	// result status
	always_comb begin
		if (fsq_q < (PROD_BITS+1)'(tol2_q))
			st_c = ST_CONV;
		else if (n_q >= limit_q)
			st_c = ST_LIMIT;
		else if (dsq_q == '0)
			st_c = ST_ZERO_D;
		else
			st_c = ST_ITER;
	end

	assign out_load = (state_q == S_DEC) && !(out_valid && !out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= RST_X4;
			coef_q[1] <= RST_X3;
			coef_q[2] <= RST_X2;
			coef_q[3] <= RST_X1;
			coef_q[4] <= RST_X0;
			tol_q <= RST_TOL;
			limit_q <= RST_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				[REG_COEF_X4:REG_COEF_X0]: coef_q[cfg_index] <= cfg_data;
				REG_TOL: tol_q <= cfg_data[TOL_BITS-1:0];
				REG_LIMIT: limit_q <= cfg_data[LIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			z_re <= zre_q;
			z_im <= zim_q;
			f_re <= pre_q;
			f_im <= pim_q;
			status <= st_c;
			last <= (st_c != ST_ITER);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exact_q <= 1'b0;
			sel_d_q <= 1'b0;
			nsel_q <= 1'b0;
			j_q <= '0;
			k_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: state_q <= S_INITD;
				S_INITD: begin
					exact_q <= 1'b0;
					sel_d_q <= 1'b0;
					k_q <= 3'd1;
					j_q <= '0;
					state_q <= S_MUL0;
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= exact_q ? S_EXP : S_RND;
				S_RND: begin
					if (j_q[1:0] == 2'd3) begin
						state_q <= S_CMB;
					end else begin
						j_q <= j_q + 4'd1;
						state_q <= S_MUL0;
					end
				end
				S_CMB: state_q <= S_ADD;
				S_ADD: begin
					j_q <= '0;
					state_q <= S_MUL0;
					if (sel_d_q) begin
						sel_d_q <= 1'b0;
					end else if (k_q == 3'd4) begin
						exact_q <= 1'b1;
					end else begin
						k_q <= k_q + 3'd1;
						sel_d_q <= 1'b1;
					end
				end
				S_EXP: begin
					if (j_q == 4'd4) begin
						state_q <= S_DEC;
					end else if (j_q == 4'd8) begin
						nsel_q <= 1'b0;
						state_q <= S_DVS;
					end else begin
						j_q <= j_q + 4'd1;
						state_q <= S_MUL0;
					end
				end
				S_DEC: begin
					if (out_load) begin
						if (st_c != ST_ITER) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= 4'd5;
							state_q <= S_MUL0;
						end
					end
				end
				S_DVS: begin
					cnt_q <= DIV_STEPS;
					state_q <= S_DVI;
				end
				S_DVI: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0)
						state_q <= S_DVF;
				end
				S_DVF: begin
					if (!nsel_q) begin
						nsel_q <= 1'b1;
						state_q <= S_DVS;
					end else begin
						n_q <= n_q + LIM_BITS'(1);
						state_q <= S_INIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				zre_q <= start_re;
				zim_q <= start_im;
			end
			S_INIT: begin
				pre_q <= sat_add(zre_q, coef_q[0]);
				pim_q <= zim_q;
			end
			S_INITD: begin
				dre_q <= sat_add(pre_q, zre_q);
				dim_q <= sat_add(pim_q, zim_q);
			end
			S_MUL0: prod_q <= PROD_BITS'(pp);
			S_MUL1: prod_q <= prod_q + (PROD_BITS'(pp) <<< HALF_BITS);
			S_RND: r_q[j_q[1:0]] <= round_sat(prod_q);
			S_CMB: begin
				cr_q <= sat_sub(r_q[0], r_q[1]);
				ci_q <= sat_add(r_q[2], r_q[3]);
			end
			S_ADD: begin
				if (sel_d_q) begin
					dre_q <= sat_add(cr_q, pre_q);
					dim_q <= sat_add(ci_q, pim_q);
				end else begin
					pre_q <= sat_add(cr_q, coef_q[k_q]);
					pim_q <= ci_q;
				end
			end
			S_EXP: begin
				case (j_q)
					4'd0: fsq_q <= {1'b0, prod_q};
					4'd1: fsq_q <= fsq_q + {1'b0, prod_q};
					4'd2: dsq_q <= {1'b0, prod_q};
					4'd3: dsq_q <= dsq_q + {1'b0, prod_q};
					4'd4: tol2_q <= prod_q[2*TOL_BITS-1:0];
					4'd5: nre_q <= {prod_q[PROD_BITS-1], prod_q};
					4'd6: nre_q <= nre_q + {prod_q[PROD_BITS-1], prod_q};
					4'd7: nim_q <= {prod_q[PROD_BITS-1], prod_q};
					default: nim_q <= nim_q - {prod_q[PROD_BITS-1], prod_q};
				endcase
			end
			S_DVS: begin
				dneg_q <= nval[PROD_BITS];
				ovf_q <= ({OVS'(0), nmag} >= {dsq_q, OVS'(0)});
				rem_q <= nmag >> OVS;
				nlo_q <= {nmag[OVS-1:0], (FRAC_BITS+1)'(0)};
				q_q <= '0;
			end
			S_DVI: begin
				if (r2 >= {1'b0, dsq_q}) begin
					rem_q <= (PROD_BITS+1)'(r2 - {1'b0, dsq_q});
					q_q <= {q_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= r2[PROD_BITS:0];
					q_q <= {q_q[QW-2:0], 1'b0};
				end
				nlo_q <= {nlo_q[QW-2:0], 1'b0};
			end
			S_DVF: begin
				if (!nsel_q)
					zre_q <= sat_sub(zre_q, qs);
				else
					zim_q <= sat_sub(zim_q, qs);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[dv/complex_newton_poly_root_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_newton_poly_root_core_tb
// Self-checking bench for the Newton root core. A bit-exact iterate predictor
// builds the expected orbit of every accepted start point, and a monitor
// compares each result transfer field by field. Directed cases cover the
// reset polynomial, word extremes, zero derivative, zero limit and extreme
// registers; random phases then vary registers, start points and stalls.
// ----------------------------------------------------------------------------
module complex_newton_poly_root_core_tb;
	import cnpr_pkg::*;

	typedef struct {
		word_t re;
		word_t im;
	} cplx_t;

	typedef struct {
		word_t      zr;
		word_t      zi;
		word_t      fr;
		word_t      fi;
		logic [1:0] st;
		logic       lst;
	} iterate_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	word_t               start_re = '0;
	word_t               start_im = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	word_t               z_re, z_im, f_re, f_im;
	logic [1:0]          status;
	logic                last;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_BITS-1:0] cfg_index = '0;
	word_t               cfg_data = '0;

	word_t               coef_m[NUM_COEF];
	logic [TOL_BITS-1:0] tol_m;
	logic [LIM_BITS-1:0] limit_m;

	iterate_t orbit_q[$];
	int       err_cnt = 0;
	bit       idle_en = 1'b1;
	int       hold_req = 0;

	complex_newton_poly_root_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_re(start_re), .start_im(start_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.z_re(z_re), .z_im(z_im), .f_re(f_re), .f_im(f_im),
		.status(status), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#300ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic word_t from_mag(logic neg, logic [191:0] m);
		logic [191:0] cap;
		cap = neg ? (192'd1 << (WORD_BITS - 1)) : ((192'd1 << (WORD_BITS - 1)) - 1);
		if (m > cap) m = cap;
		return neg ? word_t'(~m[WORD_BITS-1:0] + 1'b1) : word_t'(m[WORD_BITS-1:0]);
	endfunction

	function automatic word_t fx_add(word_t a, word_t b);
		logic signed [WORD_BITS:0] s;
		s = a + b;
		if (s > VMAX) return VMAX;
		if (s < VMIN) return VMIN;
		return word_t'(s);
	endfunction

	function automatic word_t fx_sub(word_t a, word_t b);
		logic signed [WORD_BITS:0] s;
		s = a - b;
		if (s > VMAX) return VMAX;
		if (s < VMIN) return VMIN;
		return word_t'(s);
	endfunction

	function automatic word_t fx_mul(word_t a, word_t b);
		logic signed [127:0] p;
		logic [191:0]        m;
		logic                neg;
		p = a * b;
		neg = p < 0;
		m = neg ? 192'(-p) : 192'(p);
		m = (m + (192'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return from_mag(neg, m);
	endfunction

	function automatic cplx_t c_mul(cplx_t a, cplx_t b);
		cplx_t r;
		r.re = fx_sub(fx_mul(a.re, b.re), fx_mul(a.im, b.im));
		r.im = fx_add(fx_mul(a.re, b.im), fx_mul(a.im, b.re));
		return r;
	endfunction

	function automatic cplx_t c_add(cplx_t a, cplx_t b);
		cplx_t r;
		r.re = fx_add(a.re, b.re);
		r.im = fx_add(a.im, b.im);
		return r;
	endfunction

	// round(n * 2^FRAC_BITS / d), ties away from zero, saturated
	function automatic word_t fx_div(logic signed [127:0] n, logic [127:0] d);
		logic         neg;
		logic [191:0] m, q;
		neg = n < 0;
		m = neg ? 192'(-n) : 192'(n);
		q = (m << (FRAC_BITS + 1)) / {64'd0, d};
		q = (q >> 1) + q[0];
		return from_mag(neg, q);
	endfunction

	function automatic void predict_orbit(word_t sr, word_t si);
		cplx_t               z, p, d, c;
		logic [127:0]        fsq, dsq, tol2;
		logic signed [127:0] nre, nim;
		logic [1:0]          st;
		int                  steps;
		z.re = sr;
		z.im = si;
		steps = 0;
		tol2 = tol_m * tol_m;
		c.im = '0;
		forever begin
			c.re = coef_m[0];
			p = c_add(z, c);
			d = c_add(p, z);
			c.re = coef_m[1];
			p = c_add(c_mul(p, z), c);
			for (int i = 2; i < NUM_COEF; i++) begin
				d = c_add(c_mul(d, z), p);
				c.re = coef_m[i];
				p = c_add(c_mul(p, z), c);
			end
			fsq = 128'(p.re) * 128'(p.re) + 128'(p.im) * 128'(p.im);
			dsq = 128'(d.re) * 128'(d.re) + 128'(d.im) * 128'(d.im);
			if (fsq < tol2)
				st = ST_CONV;
			else if (steps >= limit_m)
				st = ST_LIMIT;
			else if (dsq == 0)
				st = ST_ZERO_D;
			else
				st = ST_ITER;
			orbit_q.push_back('{z.re, z.im, p.re, p.im, st, st != ST_ITER});
			if (st != ST_ITER)
				break;
			nre = 128'(p.re) * 128'(d.re) + 128'(p.im) * 128'(d.im);
			nim = 128'(p.im) * 128'(d.re) - 128'(p.re) * 128'(d.im);
			z.re = fx_sub(z.re, fx_div(nre, dsq));
			z.im = fx_sub(z.im, fx_div(nim, dsq));
			steps++;
		end
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s got %h want %h", $time, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		iterate_t e;
		if (arst_n && out_valid && out_ready) begin
			if (orbit_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(z_re), 64'(0));
			end else begin
				e = orbit_q.pop_front();
				if (z_re !== e.zr) report_mismatch("z_re", 64'(z_re), 64'(e.zr));
				if (z_im !== e.zi) report_mismatch("z_im", 64'(z_im), 64'(e.zi));
				if (f_re !== e.fr) report_mismatch("f_re", 64'(f_re), 64'(e.fr));
				if (f_im !== e.fi) report_mismatch("f_im", 64'(f_im), 64'(e.fi));
				if (status !== e.st) report_mismatch("status", 64'(status), 64'(e.st));
				if (last !== e.lst) report_mismatch("last", 64'(last), 64'(e.lst));
			end
		end
	end

	// receiver: random stall bursts plus requested long hold-off
	always @(negedge clk) begin
		static int stall_left = 0;
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------- driving ----------------
	task automatic send_start(word_t sr, word_t si);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_re <= sr;
		start_im <= si;
		do @(posedge clk); while (!in_ready);
		predict_orbit(sr, si);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (orbit_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(logic [IDX_BITS-1:0] idx, word_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_TOL)
			coef_m[idx] = data;
		else if (idx == REG_TOL)
			tol_m = data[TOL_BITS-1:0];
		else if (idx == REG_LIMIT)
			limit_m = data[LIM_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_poly(word_t c4, word_t c3, word_t c2, word_t c1, word_t c0);
		cfg_write(REG_COEF_X4, c4);
		cfg_write(REG_COEF_X4 + 3'd1, c3);
		cfg_write(REG_COEF_X4 + 3'd2, c2);
		cfg_write(REG_COEF_X4 + 3'd3, c1);
		cfg_write(REG_COEF_X0, c0);
	endtask

	function automatic word_t rand_word(bit wide);
		if (wide)
			return word_t'({$urandom, $urandom});
		return word_t'($urandom_range(0, 32'h0FFF_FFFF)) - word_t'(32'h0800_0000);
	endfunction

	// ---------------- tests ----------------
	task automatic test_reset_poly();
		send_start(word_t'(40'sd50331648), '0);
		send_start(word_t'(-40'sd16777216), word_t'(40'sd33554432));
		send_start('0, '0);
		drain();
	endtask

	task automatic test_word_extremes();
		cfg_write(REG_LIMIT, word_t'(4));
		send_start(VMAX, VMAX);
		send_start(VMIN, VMIN);
		send_start(VMAX, VMIN);
		send_start(VMIN, '0);
		send_start('0, VMAX);
		send_start(word_t'(-1), word_t'(1));
		drain();
	endtask

	task automatic test_zero_derivative();
		set_poly('0, '0, '0, '0, word_t'(40'sd16777216));
		cfg_write(REG_TOL, word_t'(0));
		send_start('0, '0);
		send_start(word_t'(1), '0);
		drain();
	endtask

	task automatic test_limit_zero();
		cfg_write(REG_LIMIT, word_t'(0));
		send_start(word_t'(40'sd16777216), word_t'(-40'sd8388608));
		send_start(VMAX, VMIN);
		drain();
	endtask

	task automatic test_register_extremes();
		set_poly(VMAX, VMIN, VMAX, VMIN, VMAX);
		cfg_write(REG_TOL, word_t'(24'hFF_FFFF));
		cfg_write(REG_LIMIT, word_t'(1));
		send_start('0, '0);
		send_start(word_t'(40'sd16777216), word_t'(40'sd16777216));
		drain();
		set_poly(VMIN, VMAX, VMIN, VMAX, VMIN);
		cfg_write(REG_LIMIT, word_t'(63));
		send_start(word_t'(-40'sd4194304), word_t'(40'sd1));
		send_start(VMIN, VMAX);
		drain();
		set_poly('0, '0, '0, '0, '0);
		cfg_write(REG_TOL, word_t'(1));
		cfg_write(REG_LIMIT, word_t'(5));
		send_start('0, '0);
		send_start(word_t'(40'sd8388608), '0);
		drain();
	endtask

	task automatic test_random_phase(int n_items, bit pressure);
		bit wide;
		wide = $urandom_range(0, 4) == 0;
		set_poly(rand_word(wide), rand_word(wide), rand_word(wide), rand_word(wide),
			rand_word(wide));
		cfg_write(REG_TOL, word_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFF_FFFF)
			: $urandom_range(0, 4096)));
		cfg_write(REG_LIMIT, word_t'($urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
			: $urandom_range(1, 8)));
		if (pressure)
			hold_req = 2000;
		for (int i = 0; i < n_items; i++)
			send_start(rand_word($urandom_range(0, 3) == 0),
				rand_word($urandom_range(0, 3) == 0));
		drain();
	endtask

	initial begin
		coef_m[0] = RST_X4;
		coef_m[1] = RST_X3;
		coef_m[2] = RST_X2;
		coef_m[3] = RST_X1;
		coef_m[4] = RST_X0;
		tol_m = RST_TOL;
		limit_m = RST_LIMIT;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (5) @(posedge clk);

		test_reset_poly();
		test_word_extremes();
		test_zero_derivative();
		test_limit_zero();
		test_register_extremes();
		test_random_phase(28, 1'b1);
		for (int ph = 0; ph < 8; ph++)
			test_random_phase(28, 1'b0);
		idle_en = 1'b0;
		test_random_phase(36, 1'b0);

		repeat (300) @(posedge clk);
		if (orbit_q.size() != 0)
			report_mismatch("results missing", 64'(orbit_q.size()), 64'(0));
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
